// File: sv/sprite_slot_multiplexer_unit_defines.svh
// ----------------------------------------------------------------------------
// Sprite slot multiplexer assertion macros
// Shorthand for the clocked implication checks used by the checker module.
// ----------------------------------------------------------------------------
`ifndef SPRITE_SLOT_MULTIPLEXER_UNIT_DEFINES_SVH
`define SPRITE_SLOT_MULTIPLEXER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SSMU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sprite slot multiplexer check failed");

// Next-cycle implication, disabled while reset is high.
`define SSMU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprite slot multiplexer check failed");

`endif

// File: sv/ssm_pkg.sv
// ----------------------------------------------------------------------------
// Sprite slot multiplexer package
// Shared codes, constants and transaction types of the multiplexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

  // Input item modes.
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_PLACE  = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ACTIVE_CHANNELS = 2'd0;
  localparam logic [1:0] REG_OBJECT_HEIGHT   = 2'd1;

  localparam logic [3:0] RESET_ACTIVE_CHANNELS = 4'd8;
  localparam logic [7:0] RESET_OBJECT_HEIGHT   = 8'd16;

  // Display list arithmetic.
  localparam logic [15:0] Y_MASK       = 16'hFF00;
  localparam logic [15:0] LINE_GAP     = 16'h0200;
  localparam int          HEIGHT_SHIFT = 8;

  typedef struct packed {
    logic [3:0] active_channels;
    logic [7:0] object_height;
  } cfg_t;

  typedef struct packed {
    logic        finish;
    logic [15:0] pos;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [15:0] word_offset;
    logic [15:0] word_value;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: sv/ssm_queue.sv
// ----------------------------------------------------------------------------
// Sprite slot multiplexer queue
// Two-entry first-in first-out buffer used between the front and back ends
// and as the result buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssm_queue #(
  parameter int WIDTH = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  wr_ready,
  output logic                  rd_valid,
  output logic [WIDTH-1:0]      rd_data,
  input  wire logic             rd_take
);

  // Two slots, so each pointer is a single bit.
  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: sv/ssm_front.sv
// ----------------------------------------------------------------------------
// Sprite slot multiplexer front end
// Accepts input items, keeps the position table and turns place and finish
// items into commands for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssm_front import ssm_pkg::*; #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  table_index,
  input  wire logic [15:0] position_word,
  output logic             full,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  wire logic        cmd_ready
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  logic [15:0]   table_mem [TABLE_ENTRIES];
  logic [15:0]   rd_data;
  logic [AW-1:0] addr;
  logic          in_range;
  logic          accept;
  logic          pend_valid;
  logic          pend_finish;
  logic          pend_zero;

  assign in_range = (32'(table_index) < TABLE_ENTRIES);
  assign addr     = AW'(table_index);
  assign full     = pend_valid && !cmd_ready;
  assign accept   = push && !full;

  always_ff @(posedge clk) begin
    if (accept && (mode == MODE_LOAD) && in_range) begin
      table_mem[addr] <= position_word;
    end
    if (accept && (mode == MODE_PLACE) && in_range) begin
      rd_data <= table_mem[addr];
    end
  end

  // The pending stage waits for the table read and for room in the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        pend_valid <= 1'b0;
      end
      if (accept && ((mode == MODE_PLACE) || (mode == MODE_FINISH))) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_finish <= (mode == MODE_FINISH);
      pend_zero   <= !in_range;
    end
  end

  // An index past the table reads as zero, which always skips the object.
  assign cmd_valid  = pend_valid;
  assign cmd.finish = pend_finish;
  assign cmd.pos    = pend_zero ? 16'h0000 : rd_data;

endmodule

`default_nettype wire

// File: sv/ssm_back.sv
// ----------------------------------------------------------------------------
// Sprite slot multiplexer back end
// Holds the per-channel free lines and list offsets, searches for the
// channel with the lowest free line and produces the display list writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssm_back import ssm_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_take,
  output logic      res_valid,
  output result_t   res,
  input  wire logic res_ready
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NW = $clog2(CHANNELS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_POS   = 3'd2;
  localparam logic [2:0] ST_END   = 3'd3;
  localparam logic [2:0] ST_FIN_A = 3'd4;
  localparam logic [2:0] ST_FIN_B = 3'd5;

  logic [2:0]    state;
  logic [NW-1:0] scan_idx;
  logic [CW-1:0] best;
  logic [15:0]   best_line;
  logic [15:0]   pos;
  logic [15:0]   free_line [CHANNELS];
  logic [15:0]   list_offset [CHANNELS];

  logic [NW-1:0] used_n;
  logic [CW-1:0] rd_idx;
  logic [15:0]   cur_line;
  logic [15:0]   cur_off;
  logic [15:0]   end_word;
  logic [15:0]   off_step;
  logic          fin_last;

  always_comb begin
    if (cfg.active_channels == 4'd0) begin
      used_n = NW'(1);
    end else if (32'(cfg.active_channels) > CHANNELS) begin
      used_n = NW'(CHANNELS);
    end else begin
      used_n = NW'(cfg.active_channels);
    end
  end

  // One read port on the channel state: the scan index while searching,
  // the chosen channel otherwise.
  assign rd_idx   = (state == ST_SCAN) ? scan_idx[CW-1:0] : best;
  assign cur_line = free_line[rd_idx];
  assign cur_off  = list_offset[rd_idx];
  assign end_word = (pos & Y_MASK) + ({8'h00, cfg.object_height} << HEIGHT_SHIFT);
  assign off_step = {7'b0, cfg.object_height, 1'b0} + 16'd2;
  assign fin_last = ((NW'(best) + NW'(1)) == used_n);
  assign cmd_take = (state == ST_IDLE) && cmd_valid;

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    unique case (state)
      ST_POS: begin
        res_valid       = 1'b1;
        res.channel     = 3'(best);
        res.word_offset = cur_off;
        res.word_value  = pos;
        res.last        = 1'b0;
      end
      ST_END: begin
        res_valid       = 1'b1;
        res.channel     = 3'(best);
        res.word_offset = cur_off + 16'd1;
        res.word_value  = end_word;
        res.last        = 1'b1;
      end
      ST_FIN_A: begin
        res_valid       = 1'b1;
        res.channel     = 3'(best);
        res.word_offset = cur_off;
        res.word_value  = 16'h0000;
        res.last        = 1'b0;
      end
      ST_FIN_B: begin
        res_valid       = 1'b1;
        res.channel     = 3'(best);
        res.word_offset = cur_off + 16'd1;
        res.word_value  = 16'h0000;
        res.last        = fin_last;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int i = 0; i < CHANNELS; i++) begin
        free_line[i]   <= 16'h0000;
        list_offset[i] <= 16'h0000;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            pos  <= cmd.pos;
            best <= '0;
            if (cmd.finish) begin
              state <= ST_FIN_A;
            end else begin
              best_line <= free_line[0];
              scan_idx  <= NW'(1);
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_idx >= used_n) begin
            // The object fits only strictly below the chosen free line.
            state <= (best_line < pos) ? ST_POS : ST_IDLE;
          end else begin
            if (best_line > cur_line) begin
              best_line <= cur_line;
              best      <= scan_idx[CW-1:0];
            end
            scan_idx <= scan_idx + NW'(1);
          end
        end
        ST_POS: begin
          if (res_ready) begin
            state <= ST_END;
          end
        end
        ST_END: begin
          if (res_ready) begin
            free_line[best]   <= end_word + LINE_GAP;
            list_offset[best] <= cur_off + off_step;
            state             <= ST_IDLE;
          end
        end
        ST_FIN_A: begin
          if (res_ready) begin
            state <= ST_FIN_B;
          end
        end
        ST_FIN_B: begin
          if (res_ready) begin
            if (fin_last) begin
              for (int i = 0; i < CHANNELS; i++) begin
                free_line[i]   <= 16'h0000;
                list_offset[i] <= 16'h0000;
              end
              state <= ST_IDLE;
            end else begin
              best  <= best + CW'(1);
              state <= ST_FIN_A;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/sprite_slot_multiplexer_unit.sv
// ----------------------------------------------------------------------------
// Sprite slot multiplexer
// Assigns objects to hardware sprite channels and emits display list writes.
//
//   channel   handshake          payload
//   input     push / full        mode, table_index, position_word
//   result    pop / empty        channel, word_offset, word_value, last
//   config    cfg_valid / ready  cfg_index, cfg_data
//
// Loads finish in the front end; place and finish items go through a two-entry
// command queue to a back end that runs one command at a time. With n active
// channels a place runs dequeue, n - 1 compares, decide and two writes there;
// a skipped object ends at decide, and a finish dequeues and writes 2n words.
// Reset clears the channel state at once; table entries are undefined until loaded.
// A full result buffer stalls the back end, and a full command queue the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sprite_slot_multiplexer_unit import ssm_pkg::*; #(
  parameter int CHANNELS      = 8,
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  table_index,
  input  wire logic [15:0] position_word,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       channel,
  output logic [15:0]      word_offset,
  output logic [15:0]      word_value,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  cfg_t    cfg;
  logic    fe_valid;
  cmd_t    fe_cmd;
  logic    fe_ready;
  logic    cq_valid;
  cmd_t    cq_cmd;
  logic    cq_take;
  logic    res_valid;
  result_t res;
  logic    res_ready;
  logic    out_valid;
  result_t out_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_channels <= RESET_ACTIVE_CHANNELS;
      cfg.object_height   <= RESET_OBJECT_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACTIVE_CHANNELS: cfg.active_channels <= cfg_data[3:0];
        REG_OBJECT_HEIGHT:   cfg.object_height   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ssm_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .mode         (mode),
    .table_index  (table_index),
    .position_word(position_word),
    .full         (full),
    .cmd_valid    (fe_valid),
    .cmd          (fe_cmd),
    .cmd_ready    (fe_ready)
  );

  ssm_queue #(
    .WIDTH($bits(cmd_t))
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(fe_valid),
    .wr_data (fe_cmd),
    .wr_ready(fe_ready),
    .rd_valid(cq_valid),
    .rd_data (cq_cmd),
    .rd_take (cq_take)
  );

  ssm_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_valid(cq_valid),
    .cmd      (cq_cmd),
    .cmd_take (cq_take),
    .res_valid(res_valid),
    .res      (res),
    .res_ready(res_ready)
  );

  ssm_queue #(
    .WIDTH($bits(result_t))
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(res_valid),
    .wr_data (res),
    .wr_ready(res_ready),
    .rd_valid(out_valid),
    .rd_data (out_item),
    .rd_take (pop)
  );

  assign empty       = !out_valid;
  assign channel     = out_item.channel;
  assign word_offset = out_item.word_offset;
  assign word_value  = out_item.word_value;
  assign last        = out_item.last;

endmodule

`default_nettype wire

// File: sv/ssm_checker.sv
// ----------------------------------------------------------------------------
// Sprite slot multiplexer checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_slot_multiplexer_unit_defines.svh"

module ssm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [2:0]  channel,
  input wire logic [15:0] word_offset,
  input wire logic [15:0] word_value,
  input wire logic        last
);

  logic [35:0] head_item;

  assign head_item = {channel, word_offset, word_value, last};

  // A waiting result stays and keeps its contents until it is taken.
  `SSMU_ASSERT_NXT(a_result_held, clk, rst, !empty && !pop, !empty)
  `SSMU_ASSERT_NXT(a_result_stable, clk, rst, !empty && !pop, $stable(head_item))

  // List offsets step by an even amount, so the second word of a pair is odd.
  `SSMU_ASSERT_IMP(a_last_is_odd, clk, rst, !empty && last, word_offset[0])

  // Second words are end words or terminators, both with a clear low byte.
  `SSMU_ASSERT_IMP(a_second_word, clk, rst, !empty && word_offset[0], word_value[7:0] == 8'h00)

endmodule

bind sprite_slot_multiplexer_unit ssm_checker u_checker (.*);

`default_nettype wire

// File: bench/tb_sprite_slot_multiplexer_unit.sv
// ----------------------------------------------------------------------------
// Sprite slot multiplexer testbench
// Sends load, place, finish and ignored items through the push/full queue.
// It predicts the display list writes of every accepted item and compares
// each popped write against the oldest prediction. The run steps through
// several channel counts and object heights, draws random gaps on both
// sides, and holds off the receiver once so that the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sprite_slot_multiplexer_unit;
  import ssm_pkg::*;

  localparam int         CH_MAX        = 8;
  localparam int         CYCLE_LIMIT   = 600000;
  localparam int         SETTLE_CYCLES = 64;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         PHASE_ITEMS   = 32;
  localparam int         BURST_ITEMS   = 30;
  localparam logic [1:0] MODE_IGNORED  = 2'd3;
  localparam logic [1:0] REG_UNUSED    = 2'd3;

  // Predicts the list writes of each item and holds them until popped.
  class sprite_list_tracker;
    logic [15:0] free_line_w [CH_MAX];
    logic [15:0] list_off [CH_MAX];
    logic [15:0] pos_table [256];
    logic [3:0]  cfg_channels;
    logic [7:0]  cfg_height;
    result_t     pending_writes [$];
    int errors;
    int items;
    int writes_checked;
    int placed;
    int skipped;
    int frames;
    int settings;

    function new();
      clear_frame();
      cfg_channels   = RESET_ACTIVE_CHANNELS;
      cfg_height     = RESET_OBJECT_HEIGHT;
      errors         = 0;
      items          = 0;
      writes_checked = 0;
      placed         = 0;
      skipped        = 0;
      frames         = 0;
      settings       = 0;
    endfunction

    function void clear_frame();
      for (int j = 0; j < CH_MAX; j++) begin
        free_line_w[j] = '0;
        list_off[j]    = '0;
      end
    endfunction

    function void queue_write(logic [2:0] ch, logic [15:0] off, logic [15:0] val, logic lst);
      result_t w;
      w.channel     = ch;
      w.word_offset = off;
      w.word_value  = val;
      w.last        = lst;
      pending_writes.push_back(w);
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] data);
      if (idx == REG_ACTIVE_CHANNELS) begin
        cfg_channels = data[3:0];
      end else if (idx == REG_OBJECT_HEIGHT) begin
        cfg_height = data;
      end
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    function void take_item(logic [1:0] md, logic [7:0] idx, logic [15:0] word);
      int          n;
      int          best;
      logic [15:0] pos;
      logic [15:0] end_w;
      logic [15:0] off;
      logic [15:0] h16;
      n = cfg_channels;
      if (n < 1) n = 1;
      if (n > CH_MAX) n = CH_MAX;
      h16 = {8'h00, cfg_height};
      items++;
      case (md)
        MODE_LOAD: begin
          pos_table[idx] = word;
        end
        MODE_PLACE: begin
          pos  = pos_table[idx];
          best = 0;
          // Strict compare keeps the lowest channel on a tie.
          for (int j = 1; j < n; j++) begin
            if (free_line_w[j] < free_line_w[best]) best = j;
          end
          if (free_line_w[best] < pos) begin
            off   = list_off[best];
            end_w = (pos & Y_MASK) + (h16 << HEIGHT_SHIFT);
            queue_write(3'(best), off, pos, 1'b0);
            queue_write(3'(best), off + 16'd1, end_w, 1'b1);
            free_line_w[best] = end_w + LINE_GAP;
            list_off[best]    = off + (h16 << 1) + 16'd2;
            placed++;
          end else begin
            skipped++;
          end
        end
        MODE_FINISH: begin
          for (int j = 0; j < n; j++) begin
            queue_write(3'(j), list_off[j], 16'h0000, 1'b0);
            queue_write(3'(j), list_off[j] + 16'd1, 16'h0000, j == n - 1);
          end
          clear_frame();
          frames++;
        end
        default: begin
        end
      endcase
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task match_write(result_t got);
      result_t want;
      if (pending_writes.size() == 0) begin
        report($sformatf("unexpected write: ch %0d off %h val %h last %b",
                         got.channel, got.word_offset, got.word_value, got.last));
        return;
      end
      want = pending_writes.pop_front();
      writes_checked++;
      if (got.channel !== want.channel)
        report($sformatf("write %0d: channel %0d, expected %0d",
                         writes_checked, got.channel, want.channel));
      if (got.word_offset !== want.word_offset)
        report($sformatf("write %0d: word_offset %h, expected %h",
                         writes_checked, got.word_offset, want.word_offset));
      if (got.word_value !== want.word_value)
        report($sformatf("write %0d: word_value %h, expected %h",
                         writes_checked, got.word_value, want.word_value));
      if (got.last !== want.last)
        report($sformatf("write %0d: last %b, expected %b",
                         writes_checked, got.last, want.last));
    endtask
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        push          = 1'b0;
  logic        full;
  logic [1:0]  mode          = MODE_LOAD;
  logic [7:0]  table_index   = 8'h00;
  logic [15:0] position_word = 16'h0000;
  logic        empty;
  logic        pop           = 1'b0;
  logic [2:0]  channel;
  logic [15:0] word_offset;
  logic [15:0] word_value;
  logic        last;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index     = REG_ACTIVE_CHANNELS;
  logic [7:0]  cfg_data      = 8'h00;

  sprite_list_tracker tracker;
  int         cycle_count = 0;
  bit         hold_req    = 1'b0;
  bit         tx_idle_on  = 1'b1;
  bit         rx_idle_on  = 1'b1;
  bit         loaded [256];
  logic [7:0] loaded_idx [$];

  sprite_slot_multiplexer_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .mode          (mode),
    .table_index   (table_index),
    .position_word (position_word),
    .empty         (empty),
    .pop           (pop),
    .channel       (channel),
    .word_offset   (word_offset),
    .word_value    (word_value),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d writes outstanding.",
               cycle_count, tracker.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && pop && !empty) begin
      got.channel     = channel;
      got.word_offset = word_offset;
      got.word_value  = word_value;
      got.last        = last;
      tracker.match_write(got);
    end
  end

  // Result side: random pop gaps, plus one long hold-off on request.
  initial begin : receiver
    int gap;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 19) : 0;
      if (hold_req) begin
        gap      = gap + HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  task send_item(logic [1:0] md, logic [7:0] idx, logic [15:0] word);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    mode          <= md;
    table_index   <= idx;
    position_word <= word;
    do @(posedge clk); while (full);
    tracker.take_item(md, idx, word);
    if (md == MODE_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_idx.push_back(idx);
    end
  endtask

  task send_random_place();
    send_item(MODE_PLACE, loaded_idx[$urandom_range(0, loaded_idx.size() - 1)],
              16'($urandom));
  endtask

  // A skipped place leaves no write behind, so settle after the last one.
  task drain_idle();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Valid stays high across beats; the caller lowers it.
  task cfg_beat(logic [1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, data);
  endtask

  task program_regs(logic [7:0] ch_data, logic [7:0] h_data, bit poke_unused);
    cfg_beat(REG_ACTIVE_CHANNELS, ch_data);
    cfg_beat(REG_OBJECT_HEIGHT, h_data);
    if (poke_unused) cfg_beat(REG_UNUSED, 8'($urandom));
    cfg_valid <= 1'b0;
    tracker.settings++;
  endtask

  initial begin : stimulus
    int         pick;
    int         k;
    logic [7:0] ch_data;
    logic [7:0] h_data;
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: eight channels, height sixteen.
    send_item(MODE_LOAD, 8'd0, 16'hFFFF);
    send_item(MODE_LOAD, 8'd255, 16'h0000);
    send_item(MODE_LOAD, 8'd1, 16'h0001);
    send_item(MODE_LOAD, 8'd2, 16'h8040);
    send_item(MODE_LOAD, 8'd3, 16'hFF00);
    send_item(MODE_PLACE, 8'd255, 16'h0000);  // zero position is always skipped
    send_item(MODE_PLACE, 8'd1, 16'hFFFF);
    send_item(MODE_PLACE, 8'd2, 16'h0000);
    send_item(MODE_PLACE, 8'd3, 16'h5A5A);    // end word wraps past the top line
    send_item(MODE_PLACE, 8'd3, 16'hA5A5);
    send_item(MODE_PLACE, 8'd0, 16'h0000);
    send_item(MODE_IGNORED, 8'hFF, 16'hFFFF);
    send_item(MODE_FINISH, 8'h00, 16'h0000);

    // Zero channels acts as one channel; zero height gives a flat end word.
    drain_idle();
    program_regs(8'h00, 8'h00, 1'b0);
    send_item(MODE_PLACE, 8'd1, 16'h0000);
    send_item(MODE_PLACE, 8'd2, 16'h0000);
    send_item(MODE_PLACE, 8'd0, 16'h0000);
    send_item(MODE_FINISH, 8'hFF, 16'hFFFF);

    // A channel count above eight saturates; tallest sprites.
    drain_idle();
    program_regs(8'hFF, 8'hFF, 1'b1);
    send_item(MODE_PLACE, 8'd3, 16'h0000);
    send_item(MODE_PLACE, 8'd0, 16'h0000);
    send_item(MODE_PLACE, 8'd1, 16'h0000);
    send_item(MODE_FINISH, 8'h00, 16'h0000);

    for (int ph = 0; ph < 6; ph++) begin
      drain_idle();
      ch_data = (ph == 0) ? 8'd1 : (ph == 1 || ph == 2) ? 8'd8 : 8'($urandom);
      h_data  = (ph == 0) ? 8'd255 : (ph == 1) ? 8'd1 : 8'($urandom);
      program_regs(ch_data, h_data, ph == 3);
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);

      if (ph == 2) begin
        // Results back up while the receiver holds off and the sender keeps pushing.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = 1'b1;
        for (k = 0; k < BURST_ITEMS; k++) begin
          if (k % 3 == 0) send_random_place();
          else send_item(MODE_FINISH, 8'($urandom), 16'($urandom));
        end
        rx_idle_on = 1'b1;
      end

      k = 0;
      while (k < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          send_item(MODE_LOAD, 8'($urandom), 16'($urandom));
          k++;
        end else if (pick < 88) begin
          send_random_place();
          k++;
        end else if (pick < 95) begin
          send_item(MODE_FINISH, 8'($urandom), 16'($urandom));
          k++;
        end else begin
          send_item(MODE_IGNORED, 8'($urandom), 16'($urandom));
        end
      end
    end

    drain_idle();
    $display("Covered %0d items over %0d register settings: %0d writes checked.",
             tracker.items, tracker.settings, tracker.writes_checked);
    $display("Objects placed %0d, skipped %0d, frames finished %0d, one %0d-cycle hold-off.",
             tracker.placed, tracker.skipped, tracker.frames, HOLD_CYCLES);
    if (tracker.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
